// ----- rtl/hsg_pkg.sv -----
// hsg_pkg: constants, types and the LFSR step function of the hop sequence generator.
// No dependencies; imported by every hsg module.
package hsg_pkg;

  localparam int HOP_COUNT = 20;
  localparam int CNT_W     = $clog2(HOP_COUNT + 1);

  localparam int CHAN_W = 7;
  localparam int POS_W  = 5;
  localparam int OFF_W  = 8;
  localparam int SEED_W = 8;
  localparam int STEP_W = 7;

  localparam logic [CHAN_W-1:0] LFSR_TAPS = 7'h60;
  localparam logic [CHAN_W-1:0] CHAN_MOD  = 7'd127;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 7'd69;
  localparam logic [STEP_W-1:0] STEP_CAP  = 7'd127;
  localparam logic [SEED_W-1:0] SEED_MAX  = 8'd127;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    logic shift;
    logic live;
  } cell_ctl_t;

  function automatic chan_t lfsr_advance(input chan_t s);
    chan_t r;
    r = {1'b0, s[CHAN_W-1:1]};
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

// ----- rtl/hsg_cell.sv -----
// hsg_cell: one list cell; holds a channel, shifts it on to the next cell and
// flags a match with the broadcast candidate. Depends on hsg_pkg.
module hsg_cell import hsg_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  chan_t     d_in,
  input  chan_t     cand,
  output chan_t     d_out,
  output logic      match
);

  chan_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_r <= d_in;
    end
  end

  assign d_out = entry_r;
  assign match = ctl.live && (entry_r == cand);

endmodule

// ----- rtl/hsg_step.sv -----
// hsg_step: next LFSR state and candidate channel (state + offset) mod 127.
// Depends on hsg_pkg.
module hsg_step import hsg_pkg::*; (
  input  chan_t             lfsr,
  input  logic [OFF_W-1:0]  offset,
  output chan_t             lfsr_nxt,
  output chan_t             cand
);

  logic [OFF_W:0]  sum;
  logic [CHAN_W:0] fold;

  always_comb begin
    lfsr_nxt = lfsr_advance(lfsr);
    sum      = {2'b00, lfsr_nxt} + {1'b0, offset};
    // 128 = 1 mod 127: fold the high bits onto the low part
    fold     = {1'b0, sum[CHAN_W-1:0]} + {{(CHAN_W-1){1'b0}}, sum[OFF_W:CHAN_W]};
    if (fold >= {1'b0, CHAN_MOD}) begin
      cand = CHAN_W'(fold - {1'b0, CHAN_MOD});
    end else begin
      cand = fold[CHAN_W-1:0];
    end
  end

endmodule

// ----- rtl/hop_sequence_generator.sv -----
// hop_sequence_generator: top level; LFSR sequencer over a shifting row of list cells.
// Depends on hsg_pkg, hsg_step, hsg_cell.
//
//  channel  ports                                         handshake
//  input    in_offset[7:0] in_seed[7:0]                   start, busy
//  result   out_channel[6:0] out_position[4:0]            out_strobe (one cycle)
//           out_last out_seed_error
//
// One LFSR step per cycle; each accepted channel shifts into the cell row,
// which checks it against all earlier entries in the same cycle.
// A list ends at its 20th channel or at the step cap; each result is registered.
// A bad seed gives one error result the next cycle and leaves busy low.
// Reset is synchronous, active low; the receiver cannot stall results.
module hop_sequence_generator import hsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic [SEED_W-1:0] in_seed,
  output logic              out_strobe,
  output logic [CHAN_W-1:0] out_channel,
  output logic [POS_W-1:0]  out_position,
  output logic              out_last,
  output logic              out_seed_error
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r, state_nxt;
  chan_t             lfsr_r, lfsr_nxt;
  logic [OFF_W-1:0]  off_r;
  logic [STEP_W-1:0] steps_r;
  logic [CNT_W-1:0]  count_r;

  logic              strobe_r;
  chan_t             chan_r;
  logic [POS_W-1:0]  pos_r;
  logic              last_r;
  logic              err_r;

  chan_t             cand;
  chan_t             cell_q [HOP_COUNT];
  logic [HOP_COUNT-1:0] match;
  cell_ctl_t         ctl [HOP_COUNT];

  logic req;
  logic bad_seed;
  logic take;
  logic full;
  logic cap;
  logic done;

  assign req      = start && (state_r == ST_IDLE);
  assign bad_seed = (in_seed == '0) || (in_seed > SEED_MAX);

  hsg_step u_step (
    .lfsr     (lfsr_r),
    .offset   (off_r),
    .lfsr_nxt (lfsr_nxt),
    .cand     (cand)
  );

  assign take = (state_r == ST_RUN) && (cand <= CHAN_MAX) && !(|match);
  assign full = (count_r == CNT_W'(HOP_COUNT - 1));
  assign cap  = (steps_r == STEP_CAP - 1'b1);
  assign done = (take && full) || cap;

  genvar g;
  generate
    for (g = 0; g < HOP_COUNT; g++) begin : g_cell
      assign ctl[g].shift = take;
      assign ctl[g].live  = (count_r > CNT_W'(g));
      if (g == 0) begin : g_head
        hsg_cell u_cell (
          .clk   (clk),
          .ctl   (ctl[g]),
          .d_in  (cand),
          .cand  (cand),
          .d_out (cell_q[g]),
          .match (match[g])
        );
      end else begin : g_body
        hsg_cell u_cell (
          .clk   (clk),
          .ctl   (ctl[g]),
          .d_in  (cell_q[g-1]),
          .cand  (cand),
          .d_out (cell_q[g]),
          .match (match[g])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (req && !bad_seed) state_nxt = ST_RUN;
      ST_RUN:  if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      lfsr_r   <= '0;
      steps_r  <= '0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= take || (req && bad_seed);
      if (req && !bad_seed) begin
        lfsr_r  <= in_seed[CHAN_W-1:0];
        steps_r <= '0;
        count_r <= '0;
      end else if (state_r == ST_RUN) begin
        lfsr_r  <= lfsr_nxt;
        steps_r <= steps_r + 1'b1;
        if (take) begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req && !bad_seed) begin
      off_r <= in_offset;
    end
    if (req && bad_seed) begin
      chan_r <= '0;
      pos_r  <= '0;
      last_r <= 1'b1;
      err_r  <= 1'b1;
    end else if (take) begin
      chan_r <= cand;
      pos_r  <= POS_W'(count_r);
      last_r <= full || cap;
      err_r  <= 1'b0;
    end
  end

  assign busy           = (state_r == ST_RUN);
  assign out_strobe     = strobe_r;
  assign out_channel    = chan_r;
  assign out_position   = pos_r;
  assign out_last       = last_r;
  assign out_seed_error = err_r;

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_channel <= CHAN_MAX))
    else $error("channel out of range");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_seed_error) |-> (out_last && out_channel == '0))
    else $error("error result malformed");

  a_bad_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (req && bad_seed) |=> (out_strobe && out_seed_error && !busy))
    else $error("bad seed not reported");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last && !out_seed_error) |->
      (out_position == POS_W'(HOP_COUNT - 1)))
    else $error("list ended early");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && take && full) |=> !busy)
    else $error("sequencer did not stop after full list");

endmodule

// ----- bench/hsg_list_checker.sv -----
// hsg_list_checker: watches the request and result channels of hop_sequence_generator,
// predicts each hop list and compares every result field; depends on hsg_pkg.
module hsg_list_checker import hsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic [SEED_W-1:0] in_seed,
  input  logic              out_strobe,
  input  logic [CHAN_W-1:0] out_channel,
  input  logic [POS_W-1:0]  out_position,
  input  logic              out_last,
  input  logic              out_seed_error,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    chan_t            channel;
    logic [POS_W-1:0] position;
    logic             last;
    logic             seed_error;
  } hop_t;

  hop_t  due_hops[$];
  int    fail_count = 0;
  int    due_count  = 0;

  assign errors  = fail_count;
  assign pending = due_count;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void build_hop_list(input logic [OFF_W-1:0] off,
                                         input logic [SEED_W-1:0] sd);
    hop_t            h;
    bit [CHAN_MAX:0] taken;
    chan_t           s;
    chan_t           chans[HOP_COUNT];
    int              cand;
    int              n;
    int              steps;
    if (sd == '0 || sd > SEED_MAX) begin
      h = '{channel: '0, position: '0, last: 1'b1, seed_error: 1'b1};
      due_hops.push_back(h);
      return;
    end
    taken = '0;
    s     = sd[CHAN_W-1:0];
    n     = 0;
    steps = 0;
    while (n < HOP_COUNT && steps < STEP_CAP) begin
      s = s[0] ? ({1'b0, s[CHAN_W-1:1]} ^ LFSR_TAPS) : {1'b0, s[CHAN_W-1:1]};
      steps++;
      cand = (int'(s) + int'(off)) % int'(CHAN_MOD);
      if (cand <= CHAN_MAX && !taken[cand]) begin
        taken[cand] = 1'b1;
        chans[n]    = chan_t'(cand);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      h.channel    = chans[i];
      h.position   = i[POS_W-1:0];
      h.last       = (i == n - 1);
      h.seed_error = 1'b0;
      due_hops.push_back(h);
    end
  endfunction

  always @(posedge clk) begin
    hop_t want;
    if (rst_n) begin
      if (start === 1'b1 && busy === 1'b0)
        build_hop_list(in_offset, in_seed);
      if (out_strobe === 1'b1) begin
        if (due_hops.size() == 0) begin
          flag_mismatch("unexpected result, channel", out_channel, -1);
        end else begin
          want = due_hops.pop_front();
          if (out_channel !== want.channel)
            flag_mismatch("channel", out_channel, want.channel);
          if (out_position !== want.position)
            flag_mismatch("position", out_position, want.position);
          if (out_last !== want.last)
            flag_mismatch("last", out_last, want.last);
          if (out_seed_error !== want.seed_error)
            flag_mismatch("seed_error", out_seed_error, want.seed_error);
        end
      end
    end
    due_count = due_hops.size();
  end

endmodule

// ----- bench/tb_hop_sequence_generator.sv -----
// tb_hop_sequence_generator: drives directed and random hop list requests with idle bursts
// and gives the verdict; depends on hsg_pkg, hop_sequence_generator and hsg_list_checker.
module tb_hop_sequence_generator;
  import hsg_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [OFF_W-1:0]  in_offset;
  logic [SEED_W-1:0] in_seed;
  logic              out_strobe;
  logic [CHAN_W-1:0] out_channel;
  logic [POS_W-1:0]  out_position;
  logic              out_last;
  logic              out_seed_error;
  int                errors;
  int                pending;

  hop_sequence_generator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_offset      (in_offset),
    .in_seed        (in_seed),
    .out_strobe     (out_strobe),
    .out_channel    (out_channel),
    .out_position   (out_position),
    .out_last       (out_last),
    .out_seed_error (out_seed_error)
  );

  hsg_list_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_offset      (in_offset),
    .in_seed        (in_seed),
    .out_strobe     (out_strobe),
    .out_channel    (out_channel),
    .out_position   (out_position),
    .out_last       (out_last),
    .out_seed_error (out_seed_error),
    .errors         (errors),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // holds start high until the request is taken; leaves start high on return
  task automatic send_request(input logic [OFF_W-1:0] off, input logic [SEED_W-1:0] sd);
    in_offset <= off;
    in_seed   <= sd;
    start     <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 11);
    start <= 1'b0;
    repeat (n) begin
      in_offset <= OFF_W'($urandom_range(0, 255));
      in_seed   <= SEED_W'($urandom_range(0, 255));
      @(posedge clk);
    end
  endtask

  function automatic logic [SEED_W-1:0] pick_seed();
    if ($urandom_range(0, 99) < 82) return SEED_W'($urandom_range(1, 127));
    if ($urandom_range(0, 3) == 0)  return '0;
    return SEED_W'($urandom_range(128, 255));
  endfunction

  initial begin
    logic [OFF_W-1:0]  dir_off[18]  = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd69, 8'd70, 8'd126,
                                       8'd127, 8'd128, 8'd0, 8'd255, 8'd10, 8'd200,
                                       8'd33, 8'h55, 8'hAA, 8'd1, 8'd57};
    logic [SEED_W-1:0] dir_seed[18] = '{8'd1, 8'd127, 8'd127, 8'd1, 8'd64, 8'd85, 8'd42,
                                       8'd100, 8'd3, 8'd0, 8'd0, 8'd128, 8'd255,
                                       8'd200, 8'h2A, 8'h55, 8'd1, 8'h7F};
    rst_n     = 1'b0;
    start     = 1'b0;
    in_offset = '0;
    in_seed   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 18; i++) begin
      send_request(dir_off[i], dir_seed[i]);
      if (i % 5 == 4) idle_burst();
    end

    for (int i = 0; i < 400; i++) begin
      send_request(OFF_W'($urandom_range(0, 255)), pick_seed());
      if (i < 340 && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
